FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/tpli_pkg.sv
// Shared constants and types of the table interpolator.
package tpli_pkg;

    localparam int IDX_W  = 6;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 7;
    localparam int FRAC_W = 16;
    localparam int OUT_W  = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result selection after the table fetch
    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_LO   = 2'd1,
        MODE_HI   = 2'd2,
        MODE_MIX  = 2'd3
    } t_mode;

endpackage

FILE: hdl/table_piecewise_linear_interpolator.sv
// Top level: pipelined lower-bound search and linear interpolation over a key table.
// Loads give no result and retire after the search stages.
// Throughput: one item per cycle, held while the output register is full and
// i_m_tready is low; each search step owns a key RAM copy, the fraction divider
// retires one quotient bit per stage over 16 stages.
// Reset (i_rst_n low, synchronous) clears entry_count and all valid bits; table
// contents are not cleared and read as undefined until written.
`include "assert_macros.svh"

module table_piecewise_linear_interpolator
    import tpli_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: entry_count
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: entry_index[5:0], key_value[37:6], pressure_value[69:38],
    //        duration_value[101:70], impulse_value[133:102], zero pad[135:134]
    input  logic [135:0] i_s_tdata,
    // tuser: req_type
    input  logic         i_s_tuser,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: query_key[31:0], out_pressure[63:32], out_duration[95:64],
    //        out_impulse[127:96]
    output logic [127:0] o_m_tdata,
    // tuser: table_empty
    output logic         o_m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int S  = $clog2(TABLE_DEPTH + 1);   // search steps
    localparam int VW = VALUE_WIDTH;
    localparam int EW = KEY_W + 3 * VW;            // packed entry {im, d, p, key}
    localparam int PW = VW + FRAC_W;

    // search stage payload; loads ride along to write each RAM copy in order
    typedef struct packed {
        logic          v;
        logic          req;
        logic [AW-1:0] widx;
        logic          widx_ok;
        logic [31:0]   key;
        logic [VW-1:0] p;
        logic [VW-1:0] d;
        logic [VW-1:0] im;
        logic [CW-1:0] n;
        logic [CW-1:0] first;
        logic [CW-1:0] len;
    } t_srch;

    typedef struct packed {
        logic               v;
        logic [31:0]        key;
        t_mode              mode;
        logic [2:0][VW-1:0] base;
        logic [2:0][VW-1:0] diff;
        logic [2:0]         neg;
        logic [31:0]        rem;
        logic [31:0]        den;
        logic [FRAC_W-1:0]  q;
    } t_div;

    typedef struct packed {
        logic               v;
        logic [31:0]        key;
        t_mode              mode;
        logic [2:0][VW-1:0] base;
        logic [2:0][VW-1:0] diff;
        logic [2:0]         neg;
        logic [2:0][PW-1:0] prod;
    } t_mul;

    logic           w_ce;
    logic [CNT_W-1:0] r_count;
    logic [CW-1:0]  w_n;

    t_srch          w_ent [0:S];
    t_srch          r_s   [0:S];
    logic [31:0]    w_kd  [0:S-1];
    logic [S:0]     w_sv;

    t_div           w_dent [0:FRAC_W];
    t_div           r_d    [0:FRAC_W];
    t_mul           r_m;
    logic           r_ov;
    logic [127:0]   r_odata;
    logic           r_ouser;

    // whole pipeline advances together; it stalls only while the output register holds an untaken result
    assign w_ce       = !r_ov || i_m_tready;
    assign o_s_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // count above the depth acts as the depth
    assign w_n = (32'(r_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_count);

    always_comb begin
        w_ent[0].v       = i_s_tvalid;
        w_ent[0].req     = i_s_tuser;
        w_ent[0].widx    = AW'(i_s_tdata[5:0]);
        w_ent[0].widx_ok = (32'(i_s_tdata[5:0]) < 32'(TABLE_DEPTH));
        w_ent[0].key     = i_s_tdata[37:6];
        w_ent[0].p       = VW'(i_s_tdata[69:38]);
        w_ent[0].d       = VW'(i_s_tdata[101:70]);
        w_ent[0].im      = VW'(i_s_tdata[133:102]);
        w_ent[0].n       = w_n;
        w_ent[0].first   = '0;
        w_ent[0].len     = w_n;
    end

    // lower-bound search, one step and one key RAM copy per stage
    for (genvar k = 0; k < S; k++) begin : g_search
        logic [CW-1:0] w_half;
        logic [CW-1:0] w_mid;

        tpli_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key (
            .i_clk   (i_clk),
            .i_we    (w_ce && w_ent[k].v && (w_ent[k].req == REQ_LOAD) && w_ent[k].widx_ok),
            .i_waddr (w_ent[k].widx),
            .i_wdata (w_ent[k].key),
            .i_re    (w_ce),
            .i_raddr (AW'(w_ent[k].first + (w_ent[k].len >> 1))),
            .o_rdata (w_kd[k])
        );

        always_comb begin
            w_half     = r_s[k].len >> 1;
            w_mid      = r_s[k].first + w_half;
            w_ent[k+1] = r_s[k];
            if (r_s[k].len != '0) begin
                if (w_kd[k] < r_s[k].key) begin
                    w_ent[k+1].first = w_mid + CW'(1);
                    w_ent[k+1].len   = r_s[k].len - w_half - CW'(1);
                end else begin
                    w_ent[k+1].len = w_half;
                end
            end
        end
    end

    for (genvar k = 0; k <= S; k++) begin : g_sreg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[k].v <= 1'b0;
            end else if (w_ce) begin
                r_s[k] <= w_ent[k];
            end
        end
        assign w_sv[k] = r_s[k].v;
    end

    // fetch of the bracketing entries
    logic [CW-1:0] w_fhi;
    logic [CW-1:0] w_flo;
    logic [EW-1:0] w_ehi;
    logic [EW-1:0] w_elo;
    logic          w_fwe;
    logic [EW-1:0] w_fwdata;

    always_comb begin
        if (w_ent[S].first == '0) begin
            w_fhi = '0;
        end else if (w_ent[S].first >= w_ent[S].n) begin
            w_fhi = w_ent[S].n - CW'(1);
        end else begin
            w_fhi = w_ent[S].first;
        end
        w_flo    = w_ent[S].first - CW'(1);
        w_fwe    = w_ce && w_ent[S].v && (w_ent[S].req == REQ_LOAD) && w_ent[S].widx_ok;
        w_fwdata = {w_ent[S].im, w_ent[S].d, w_ent[S].p, w_ent[S].key};
    end

    tpli_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_hi (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_ent[S].widx),
        .i_wdata (w_fwdata),
        .i_re    (w_ce),
        .i_raddr (AW'(w_fhi)),
        .o_rdata (w_ehi)
    );

    tpli_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_lo (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_ent[S].widx),
        .i_wdata (w_fwdata),
        .i_re    (w_ce),
        .i_raddr (AW'(w_flo)),
        .o_rdata (w_elo)
    );

    // classify the query and set up the fraction divide
    always_comb begin
        logic [31:0]        khi;
        logic [31:0]        klo;
        logic [2:0][VW-1:0] vhi;
        logic [2:0][VW-1:0] vlo;
        logic               edge_hit;

        khi      = w_ehi[KEY_W-1:0];
        klo      = w_elo[KEY_W-1:0];
        vhi      = w_ehi[EW-1:KEY_W];
        vlo      = w_elo[EW-1:KEY_W];
        edge_hit = (r_s[S].first == '0) || (r_s[S].first >= r_s[S].n);

        w_dent[0].v   = r_s[S].v && (r_s[S].req == REQ_QUERY);
        w_dent[0].key = r_s[S].key;
        if (r_s[S].n == '0) begin
            w_dent[0].mode = MODE_ZERO;
            w_dent[0].key  = '0;
        end else if (edge_hit || (r_s[S].key >= khi)) begin
            w_dent[0].mode = MODE_HI;
        end else if ((khi <= klo) || (r_s[S].key <= klo)) begin
            w_dent[0].mode = MODE_LO;
        end else begin
            w_dent[0].mode = MODE_MIX;
        end

        for (int i = 0; i < 3; i++) begin
            case (w_dent[0].mode)
                MODE_ZERO: w_dent[0].base[i] = '0;
                MODE_HI:   w_dent[0].base[i] = vhi[i];
                default:   w_dent[0].base[i] = vlo[i];
            endcase
            w_dent[0].neg[i]  = vhi[i] < vlo[i];
            w_dent[0].diff[i] = w_dent[0].neg[i] ? (vlo[i] - vhi[i]) : (vhi[i] - vlo[i]);
        end
        w_dent[0].rem = r_s[S].key - klo;
        w_dent[0].den = khi - klo;
        w_dent[0].q   = '0;
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < FRAC_W; j++) begin : g_div
        logic [32:0] w_r2;
        logic        w_ge;
        always_comb begin
            w_r2           = {r_d[j].rem, 1'b0};
            w_ge           = w_r2 >= {1'b0, r_d[j].den};
            w_dent[j+1]    = r_d[j];
            w_dent[j+1].rem = w_ge ? 32'(w_r2 - {1'b0, r_d[j].den}) : w_r2[31:0];
            w_dent[j+1].q   = {r_d[j].q[FRAC_W-2:0], w_ge};
        end
    end

    for (genvar j = 0; j <= FRAC_W; j++) begin : g_dreg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[j].v <= 1'b0;
            end else if (w_ce) begin
                r_d[j] <= w_dent[j];
            end
        end
    end

    // fraction times value span
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_m.key  <= r_d[FRAC_W].key;
            r_m.mode <= r_d[FRAC_W].mode;
            r_m.base <= r_d[FRAC_W].base;
            r_m.diff <= r_d[FRAC_W].diff;
            r_m.neg  <= r_d[FRAC_W].neg;
            for (int i = 0; i < 3; i++) begin
                r_m.prod[i] <= PW'(r_d[FRAC_W].q) * PW'(r_d[FRAC_W].diff[i]);
            end
        end
        if (!i_rst_n) begin
            r_m.v <= 1'b0;
        end else if (w_ce) begin
            r_m.v <= r_d[FRAC_W].v;
        end
    end

    // final add toward the upper value, into the output register
    logic [2:0][VW-1:0] w_res;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_m.mode == MODE_MIX) begin
                w_res[i] = r_m.neg[i] ? (r_m.base[i] - r_m.prod[i][PW-1:FRAC_W])
                                      : (r_m.base[i] + r_m.prod[i][PW-1:FRAC_W]);
            end else begin
                w_res[i] = r_m.base[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_odata <= {OUT_W'(w_res[2]), OUT_W'(w_res[1]), OUT_W'(w_res[0]), r_m.key};
            r_ouser <= (r_m.mode == MODE_ZERO);
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ce) begin
            r_ov <= r_m.v;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    `ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == '0)
    `ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_ce, $stable(w_sv))
    `ASSERT_IMP(a_frac_span, i_clk, i_rst_n, r_m.v && (r_m.mode == MODE_MIX), r_m.prod[0][PW-1:FRAC_W] <= r_m.diff[0])

endmodule

FILE: hdl/tpli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for table_piecewise_linear_interpolator: loads, queries, backpressure.
module tb_top;
    import tpli_pkg::*;

    localparam int DEPTH     = 64;
    localparam int SETTLE    = 40;       // pipeline is 27 deep; loads retire silently
    localparam int RUN_LIMIT = 7200000;  // simulation timeout

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] pres;
        logic [31:0] dur;
        logic [31:0] imp;
        logic        empty;
    } t_interp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [6:0]   i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [135:0] i_s_tdata = '0;   // entry_index, key, pressure, duration, impulse, pad
    logic         i_s_tuser = 1'b0; // req_type
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;        // query_key, pressure, duration, impulse
    logic         o_m_tuser;        // table_empty

    table_piecewise_linear_interpolator DUT (.*);

    always #6 i_clk = ~i_clk;

    // shadow of the table and the count register
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_pres[DEPTH];
    logic [31:0] tbl_dur [DEPTH];
    logic [31:0] tbl_imp [DEPTH];
    logic [6:0]  shadow_count = '0;

    t_interp pending_results[$];
    int      mismatches = 0;
    int      n_loads = 0, n_queries = 0, n_results = 0, n_empty = 0, n_configs = 0;
    bit      quiet_tx = 0, quiet_rx = 0;  // stretches with no idling
    int      rx_hold = 0;                 // cycles left in a long sink stall

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------
    function automatic logic [31:0] lerp(logic [31:0] lo, logic [31:0] hi,
                                         logic [15:0] frac);
        logic [63:0] span;
        if (hi >= lo) begin
            span = ({32'd0, hi - lo} * frac) >> 16;
            return lo + span[31:0];
        end
        span = ({32'd0, lo - hi} * frac) >> 16;
        return lo - span[31:0];
    endfunction

    function automatic t_interp interpolate(logic [31:0] key);
        t_interp r;
        int n, first, len, half, mid, lo, hi;
        logic [63:0] frac;
        r = '0;
        n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
        if (n == 0) begin
            r.empty = 1'b1;
            return r;
        end
        r.key = key;
        first = 0;
        len = n;
        // lower bound: first slot whose key is not below the query
        while (len > 0) begin
            half = len >> 1;
            mid = first + half;
            if (tbl_key[mid] < key) begin
                first = mid + 1;
                len -= half + 1;
            end else begin
                len = half;
            end
        end
        if (first == 0 || first >= n) begin
            lo = (first == 0) ? 0 : n - 1;
            r.pres = tbl_pres[lo];
            r.dur = tbl_dur[lo];
            r.imp = tbl_imp[lo];
            return r;
        end
        hi = first;
        lo = first - 1;
        if (key >= tbl_key[hi]) begin
            r.pres = tbl_pres[hi];
            r.dur = tbl_dur[hi];
            r.imp = tbl_imp[hi];
        end else if (tbl_key[hi] <= tbl_key[lo] || key <= tbl_key[lo]) begin
            // not strictly ascending, or query on the lower key
            r.pres = tbl_pres[lo];
            r.dur = tbl_dur[lo];
            r.imp = tbl_imp[lo];
        end else begin
            frac = ({32'd0, key - tbl_key[lo]} << 16) / {32'd0, tbl_key[hi] - tbl_key[lo]};
            if (frac > 64'hFFFF) frac = 64'hFFFF;
            r.pres = lerp(tbl_pres[lo], tbl_pres[hi], frac[15:0]);
            r.dur = lerp(tbl_dur[lo], tbl_dur[hi], frac[15:0]);
            r.imp = lerp(tbl_imp[lo], tbl_imp[hi], frac[15:0]);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one item and wait for its handshake, then predict
    task automatic send_item(logic req, logic [5:0] idx, logic [31:0] key,
                             logic [31:0] p = 0, logic [31:0] d = 0, logic [31:0] im = 0);
        int gap;
        gap = quiet_tx ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= req;
        i_s_tdata <= {2'b00, im, d, p, key, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (req == REQ_LOAD) begin
            tbl_key[idx] = key;
            tbl_pres[idx] = p;
            tbl_dur[idx] = d;
            tbl_imp[idx] = im;
            n_loads++;
        end else begin
            pending_results.push_back(interpolate(key));
            n_queries++;
        end
    endtask

    task automatic load_entry(int idx, logic [31:0] key, logic [31:0] p,
                              logic [31:0] d, logic [31:0] im);
        send_item(REQ_LOAD, idx[5:0], key, p, d, im);
    endtask

    task automatic query(logic [31:0] key);
        send_item(REQ_QUERY, 6'($urandom()), key, $urandom(), $urandom(), $urandom());
    endtask

    // drain, let silent loads retire, then write the count register
    task automatic set_count(logic [6:0] cnt);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_count = cnt;
        n_configs++;
    endtask

    // ---------------------------------------------------------------------
    // result checker and sink-side stalls
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_interp got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[95:64],
                   o_m_tdata[127:96], o_m_tuser};
            n_results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result key=%h", got.key);
            end else begin
                want = pending_results.pop_front();
                if (want.empty) n_empty++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: key %h exp p=%h d=%h i=%h e=%b got k=%h p=%h d=%h i=%h e=%b",
                                 want.key, want.pres, want.dur, want.imp, want.empty,
                                 got.key, got.pres, got.dur, got.imp, got.empty);
                end
            end
        end
        // mostly ready, short stalls, an occasional long one
        if (quiet_rx) begin
            i_m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            rx_hold <= $urandom_range(8, 40);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) < 70) ||
                          (!i_m_tready && $urandom_range(0, 99) < 40);
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) quiet_rx <= ~quiet_rx;
        if ($urandom_range(0, 499) == 0) quiet_tx <= ~quiet_tx;
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    task automatic test_empty_table();
        query(32'h0);
        query(32'hFFFF_FFFF);
        query($urandom());
    endtask

    // small hand-built table: clamps, exact hits, interpolation both ways
    task automatic test_small_table();
        load_entry(0, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1234);
        load_entry(1, 32'h0003_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_1234);
        load_entry(2, 32'h0003_0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        load_entry(3, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        set_count(7'd4);
        query(32'h0000_0000);     // below first key
        query(32'h0001_0000);     // exact first
        query(32'h0002_0000);     // midway, rising and falling values
        query(32'h0002_FFFF);     // fraction near one
        query(32'h0001_0001);     // fraction near zero
        query(32'h0003_0000);     // exact on duplicate keys
        query(32'h0003_0001);     // into last segment
        query(32'hFFFF_FFFE);     // exact last
        query(32'hFFFF_FFFF);     // above last key
        set_count(7'd1);
        query(32'h0000_0000);
        query(32'hFFFF_FFFF);
        // unsorted: slot 2 below slot 1
        load_entry(2, 32'h0000_8000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        set_count(7'd4);
        query(32'h0000_9000);
        query(32'h0002_0000);
        query(32'h8000_0000);
    endtask

    // whole table refreshed per round; sorted keys mostly, one unsorted round
    task automatic test_random_tables(int rounds, int items_per_round);
        logic [31:0] keys[$];
        logic [31:0] k, lo_k, hi_k;
        int n, j, r;
        for (int rnd = 0; rnd < rounds; rnd++) begin
            keys.delete();
            for (int i = 0; i < DEPTH; i++) begin
                if (rnd % 3 == 1) keys.push_back($urandom_range(0, 255) << 16);  // duplicates
                else keys.push_back($urandom());
            end
            if (rnd != 5) keys.sort();
            if (rnd == 2) keys[DEPTH - 1] = 32'hFFFF_FFFF;
            if (rnd == 2) keys[0] = 32'h0;
            for (int i = 0; i < DEPTH; i++)
                load_entry(i, keys[i], $urandom(), $urandom(), $urandom());
            case (rnd)
                0: set_count(7'd64);
                1: set_count(7'd127);
                2: set_count(7'd2);
                3: set_count(7'd65);
                4: set_count(7'd0);
                default: set_count(7'($urandom_range(1, 127)));
            endcase
            n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
            for (int it = 0; it < items_per_round; it++) begin
                r = $urandom_range(0, 99);
                j = $urandom_range(0, (n > 0 ? n : 1) - 1);
                if (r < 12) begin
                    // rewrite values, mostly keeping the key so ordering survives
                    if (r < 2) k = $urandom(); else k = tbl_key[j];
                    load_entry(j, k, $urandom(), $urandom(), $urandom());
                end else begin
                    if (n == 0 || r < 30) k = $urandom();
                    else if (r < 45) k = tbl_key[j];
                    else if (r < 52) k = tbl_key[j] + ($urandom_range(0, 1) ? 1 : -1);
                    else if (r < 56) k = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
                    else if (j + 1 < n) begin
                        lo_k = tbl_key[j];
                        hi_k = tbl_key[j + 1];
                        k = (hi_k > lo_k) ? lo_k + ($urandom() % (hi_k - lo_k)) : lo_k;
                    end else k = $urandom();
                    query(k);
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_small_table();
        test_random_tables(8, 110);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d loads, %0d queries, %0d results (%0d on empty table), %0d count writes",
                 n_loads, n_queries, n_results, n_empty, n_configs);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) $display("table_piecewise_linear_interpolator verification clean");
        else $display("table_piecewise_linear_interpolator verification failed");
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("table_piecewise_linear_interpolator verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tpli_pkg.sv
hdl/tpli_ram.sv
hdl/table_piecewise_linear_interpolator.sv
sim/tb_top.sv
